/* src/cff_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cff_pkg: shared types and helpers for the contact friction force pipeline
// Stage records, integer square root step and 32 bit saturation.
// ----------------------------------------------------------------------------
package cff_pkg;

  localparam int SqrtSteps  = 31;
  localparam int StatSteps  = 16;
  localparam int LenTopBit  = 60;
  localparam int StatTopBit = 30;
  localparam int DivSteps   = 17;
  localparam int TailStages = 6;
  localparam int HeadStages = 7;
  localparam int Latency    = HeadStages + SqrtSteps + 1 + DivSteps + 1 + TailStages;

  localparam logic signed [65:0] S32Max = 66'sh0_7FFF_FFFF;
  localparam logic signed [65:0] S32Min = -66'sh0_8000_0000;

  typedef struct packed {
    logic signed [31:0] vx;
    logic signed [31:0] vy;
    logic [30:0]        dep;
    logic [46:0]        slide;
    logic [31:0]        sprod;
    logic               neg_x;
    logic               neg_y;
    logic               zero;
  } ctx_t;

  typedef struct packed {
    logic [63:0] x;
    logic [63:0] r;
  } root_t;

  typedef struct packed {
    ctx_t        ctx;
    logic [29:0] ax;
    logic [29:0] ay;
    root_t       len;
    root_t       stat;
  } sq_t;

  typedef struct packed {
    ctx_t        ctx;
    logic [30:0] len;
    logic [15:0] stat;
    logic [47:0] rx;
    logic [47:0] ry;
    logic [16:0] qx;
    logic [16:0] qy;
  } dv_t;

  function automatic root_t root_step(input root_t s, input logic [63:0] b);
    root_t       o;
    logic [63:0] t;
    t = s.r + b;
    if (s.x >= t) begin
      o.x = s.x - t;
      o.r = (s.r >> 1) + b;
    end else begin
      o.x = s.x;
      o.r = s.r >> 1;
    end
    return o;
  endfunction

  function automatic logic signed [31:0] sat32(input logic signed [65:0] x);
    logic signed [31:0] o;
    if (x > S32Max) begin
      o = 32'sh7FFF_FFFF;
    end else if (x < S32Min) begin
      o = -32'sh8000_0000;
    end else begin
      o = 32'(x);
    end
    return o;
  endfunction

endpackage
`default_nettype wire

/* src/contact_friction_force.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// contact_friction_force: Coulomb friction force for one 2-D contact
// Tangent extraction, normalization, stick/slide decision and force, fixed
// point, fully pipelined.
// ----------------------------------------------------------------------------
// Usage:
//   Drive one contact word on the input ports and raise start_i. The word is
//   taken at the rising edge where start_i is high and busy_o is low; busy_o
//   stays low, so a new contact may enter on every cycle.
//   Each contact yields one result word: force_x_o, force_y_o and sticking_o
//   are valid for the single cycle in which done_o is high. Results leave in
//   the order the contacts came in.
//   Throughput is one contact per cycle. Latency is set by the integer square
//   root of the tangent length (one bit per stage, 31 stages) and the restoring
//   divider that forms the unit tangent (one quotient bit per stage, 17 stages)
//   plus the multiply, normalize and decision stages around them.
//   The receiver cannot stall; done_o must be sampled when it is high.
//   Reset clears every stage valid bit; words in flight are dropped and
//   done_o stays low until a new contact has passed the pipeline.
// ----------------------------------------------------------------------------
module contact_friction_force
  import cff_pkg::*;
(
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               start_i,
  output logic                    busy_o,
  input  wire logic signed [31:0] normal_x_i,
  input  wire logic signed [31:0] normal_y_i,
  input  wire logic signed [31:0] velocity_x_i,
  input  wire logic signed [31:0] velocity_y_i,
  input  wire logic [30:0]        depth_i,
  input  wire logic [15:0]        dyn_coef_a_i,
  input  wire logic [15:0]        dyn_coef_b_i,
  input  wire logic [15:0]        stat_coef_a_i,
  input  wire logic [15:0]        stat_coef_b_i,
  output logic                    done_o,
  output logic signed [31:0]      force_x_o,
  output logic signed [31:0]      force_y_o,
  output logic                    sticking_o
);

  // stage 1: velocity dot normal products, coefficient prep
  logic               v1_q;
  logic signed [31:0] vx1_q, vy1_q, nx1_q, ny1_q;
  logic [30:0]        dep1_q;
  logic [15:0]        dyn1_q;
  logic [31:0]        sprod1_q;
  logic signed [63:0] pxn1_q, pyn1_q;

  // stage 2: saturated normal speed
  logic               v2_q;
  logic signed [31:0] vx2_q, vy2_q, nx2_q, ny2_q;
  logic [30:0]        dep2_q;
  logic [46:0]        slide2_q;
  logic [31:0]        sprod2_q;
  logic signed [31:0] d2_q;

  // stage 3: normal component products
  logic               v3_q;
  logic signed [31:0] vx3_q, vy3_q;
  logic [30:0]        dep3_q;
  logic [46:0]        slide3_q;
  logic [31:0]        sprod3_q;
  logic signed [63:0] qx3_q, qy3_q;

  // stage 4: tangent magnitudes
  logic               v4_q;
  ctx_t               ctx4_q, ctx4_d;
  logic [47:0]        ax4_q, ay4_q, ax4_d, ay4_d;
  logic signed [48:0] tx4, ty4;

  // stage 5: leading one search
  logic               v5_q;
  ctx_t               ctx5_q;
  logic [47:0]        ax5_q, ay5_q, m4;
  logic [5:0]         sh5_q, sh5_d;

  // stage 6: normalized magnitudes
  logic               v6_q;
  ctx_t               ctx6_q;
  logic [29:0]        ax6_q, ay6_q;
  logic [76:0]        wx5, wy5;

  // stage 7: squares
  logic               v7_q;
  ctx_t               ctx7_q;
  logic [29:0]        ax7_q, ay7_q;
  logic [59:0]        sqx7_q, sqy7_q;

  // square root and divider chains
  logic               sq_v_q [0:SqrtSteps];
  sq_t                sq_q   [0:SqrtSteps];
  logic               dv_v_q [0:DivSteps];
  dv_t                dv_q   [0:DivSteps];

  // tail stages
  logic               t1_v_q, t2_v_q, t3_v_q, t4_v_q, t5_v_q;
  ctx_t               t1_ctx_q, t2_ctx_q, t3_ctx_q, t4_ctx_q;
  logic signed [17:0] t1_ux_q, t1_uy_q, t2_ux_q, t2_uy_q, t3_ux_q, t3_uy_q;
  logic signed [17:0] t4_ux_q, t4_uy_q;
  logic signed [17:0] ux_d, uy_d;
  logic [46:0]        t1_thr_q, t2_thr_q, t3_thr_q;
  logic signed [49:0] t2_px_q, t2_py_q;
  logic signed [35:0] t3_jt_q, t4_jt_q, jt_d;
  logic signed [50:0] jsum;
  logic [35:0]        jm;
  logic               t4_stick_q, t5_stick_q, stick_d;
  logic signed [47:0] op5;
  logic signed [65:0] t5_fx_q, t5_fy_q, shx, shy;

  logic               done_q, sticking_q;
  logic signed [31:0] force_x_q, force_y_q;

  logic               accept;

  assign busy_o = 1'b0;
  assign accept = start_i && !busy_o;

  // stage 4 combinational
  always_comb begin
    tx4 = 49'(vx3_q) - 49'(qx3_q >>> 16);
    ty4 = 49'(vy3_q) - 49'(qy3_q >>> 16);
    ax4_d = tx4[48] ? 48'(-tx4) : tx4[47:0];
    ay4_d = ty4[48] ? 48'(-ty4) : ty4[47:0];
    ctx4_d.vx    = vx3_q;
    ctx4_d.vy    = vy3_q;
    ctx4_d.dep   = dep3_q;
    ctx4_d.slide = slide3_q;
    ctx4_d.sprod = sprod3_q;
    ctx4_d.neg_x = tx4[48];
    ctx4_d.neg_y = ty4[48];
    ctx4_d.zero  = (tx4 == '0) && (ty4 == '0);
  end

  // stage 5 combinational: position of the leading one
  always_comb begin
    m4 = (ax4_q > ay4_q) ? ax4_q : ay4_q;
    sh5_d = '0;
    for (int k = 0; k < 48; k++) begin
      if (m4[k]) begin
        sh5_d = 6'(k);
      end
    end
  end

  // stage 6 combinational: bring the larger magnitude into [2^29, 2^30)
  always_comb begin
    wx5 = {ax5_q, 29'b0} >> sh5_q;
    wy5 = {ay5_q, 29'b0} >> sh5_q;
  end

  // tail combinational
  always_comb begin
    ux_d = dv_q[DivSteps].ctx.neg_x ? -$signed({1'b0, dv_q[DivSteps].qx})
                                    : $signed({1'b0, dv_q[DivSteps].qx});
    uy_d = dv_q[DivSteps].ctx.neg_y ? -$signed({1'b0, dv_q[DivSteps].qy})
                                    : $signed({1'b0, dv_q[DivSteps].qy});
    if (dv_q[DivSteps].ctx.zero) begin
      ux_d = '0;
      uy_d = '0;
    end
    jsum  = 51'(t2_px_q) + 51'(t2_py_q);
    jt_d  = -36'(jsum >>> 16);
    jm    = t3_jt_q[35] ? 36'(-t3_jt_q) : t3_jt_q;
    stick_d = {jm, 12'b0} < {1'b0, t3_thr_q};
    op5   = t4_stick_q ? 48'(t4_jt_q) : -$signed({1'b0, t4_ctx_q.slide});
    shx   = t5_stick_q ? (t5_fx_q >>> 16) : (t5_fx_q >>> 28);
    shy   = t5_stick_q ? (t5_fy_q >>> 16) : (t5_fy_q >>> 28);
  end

  // valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q      <= 1'b0;
      v2_q      <= 1'b0;
      v3_q      <= 1'b0;
      v4_q      <= 1'b0;
      v5_q      <= 1'b0;
      v6_q      <= 1'b0;
      v7_q      <= 1'b0;
      sq_v_q[0] <= 1'b0;
      dv_v_q[0] <= 1'b0;
      t1_v_q    <= 1'b0;
      t2_v_q    <= 1'b0;
      t3_v_q    <= 1'b0;
      t4_v_q    <= 1'b0;
      t5_v_q    <= 1'b0;
      done_q    <= 1'b0;
    end else begin
      v1_q      <= accept;
      v2_q      <= v1_q;
      v3_q      <= v2_q;
      v4_q      <= v3_q;
      v5_q      <= v4_q;
      v6_q      <= v5_q;
      v7_q      <= v6_q;
      sq_v_q[0] <= v7_q;
      dv_v_q[0] <= sq_v_q[SqrtSteps];
      t1_v_q    <= dv_v_q[DivSteps];
      t2_v_q    <= t1_v_q;
      t3_v_q    <= t2_v_q;
      t4_v_q    <= t3_v_q;
      t5_v_q    <= t4_v_q;
      done_q    <= t5_v_q;
    end
  end

  // payload
  always_ff @(posedge clk_i) begin
    vx1_q    <= velocity_x_i;
    vy1_q    <= velocity_y_i;
    nx1_q    <= normal_x_i;
    ny1_q    <= normal_y_i;
    dep1_q   <= depth_i;
    dyn1_q   <= (dyn_coef_a_i < dyn_coef_b_i) ? dyn_coef_a_i : dyn_coef_b_i;
    sprod1_q <= 32'(stat_coef_a_i) * 32'(stat_coef_b_i);
    pxn1_q   <= 64'(velocity_x_i) * 64'(normal_x_i);
    pyn1_q   <= 64'(velocity_y_i) * 64'(normal_y_i);

    vx2_q    <= vx1_q;
    vy2_q    <= vy1_q;
    nx2_q    <= nx1_q;
    ny2_q    <= ny1_q;
    dep2_q   <= dep1_q;
    sprod2_q <= sprod1_q;
    slide2_q <= 47'(dep1_q) * 47'(dyn1_q);
    d2_q     <= sat32(66'(pxn1_q >>> 16) + 66'(pyn1_q >>> 16));

    vx3_q    <= vx2_q;
    vy3_q    <= vy2_q;
    dep3_q   <= dep2_q;
    slide3_q <= slide2_q;
    sprod3_q <= sprod2_q;
    qx3_q    <= 64'(d2_q) * 64'(nx2_q);
    qy3_q    <= 64'(d2_q) * 64'(ny2_q);

    ctx4_q   <= ctx4_d;
    ax4_q    <= ax4_d;
    ay4_q    <= ay4_d;

    ctx5_q      <= ctx4_q;
    ax5_q       <= ax4_q;
    ay5_q       <= ay4_q;
    sh5_q       <= sh5_d;

    ctx6_q   <= ctx5_q;
    ax6_q    <= wx5[29:0];
    ay6_q    <= wy5[29:0];

    ctx7_q   <= ctx6_q;
    ax7_q    <= ax6_q;
    ay7_q    <= ay6_q;
    sqx7_q   <= 60'(ax6_q) * 60'(ax6_q);
    sqy7_q   <= 60'(ay6_q) * 60'(ay6_q);

    sq_q[0].ctx    <= ctx7_q;
    sq_q[0].ax     <= ax7_q;
    sq_q[0].ay     <= ay7_q;
    sq_q[0].len.x  <= 64'(sqx7_q) + 64'(sqy7_q);
    sq_q[0].len.r  <= '0;
    sq_q[0].stat.x <= 64'(ctx7_q.sprod);
    sq_q[0].stat.r <= '0;

    dv_q[0].ctx  <= sq_q[SqrtSteps].ctx;
    dv_q[0].len  <= sq_q[SqrtSteps].len.r[30:0];
    dv_q[0].stat <= sq_q[SqrtSteps].stat.r[15:0];
    dv_q[0].rx   <= {2'b0, sq_q[SqrtSteps].ax, 16'b0};
    dv_q[0].ry   <= {2'b0, sq_q[SqrtSteps].ay, 16'b0};
    dv_q[0].qx   <= '0;
    dv_q[0].qy   <= '0;

    t1_ctx_q <= dv_q[DivSteps].ctx;
    t1_ux_q  <= ux_d;
    t1_uy_q  <= uy_d;
    t1_thr_q <= 47'(dv_q[DivSteps].ctx.dep) * 47'(dv_q[DivSteps].stat);

    t2_ctx_q <= t1_ctx_q;
    t2_ux_q  <= t1_ux_q;
    t2_uy_q  <= t1_uy_q;
    t2_thr_q <= t1_thr_q;
    t2_px_q  <= 50'(t1_ctx_q.vx) * 50'(t1_ux_q);
    t2_py_q  <= 50'(t1_ctx_q.vy) * 50'(t1_uy_q);

    t3_ctx_q <= t2_ctx_q;
    t3_ux_q  <= t2_ux_q;
    t3_uy_q  <= t2_uy_q;
    t3_thr_q <= t2_thr_q;
    t3_jt_q  <= jt_d;

    t4_ctx_q   <= t3_ctx_q;
    t4_ux_q    <= t3_ux_q;
    t4_uy_q    <= t3_uy_q;
    t4_jt_q    <= t3_jt_q;
    t4_stick_q <= stick_d;

    t5_stick_q <= t4_stick_q;
    t5_fx_q    <= 66'(t4_ux_q) * 66'(op5);
    t5_fy_q    <= 66'(t4_uy_q) * 66'(op5);

    sticking_q <= t5_stick_q;
    force_x_q  <= sat32(shx);
    force_y_q  <= sat32(shy);
  end

  // square root: one result bit per stage, static coefficient root alongside
  for (genvar i = 0; i < SqrtSteps; i++) begin : g_sqrt
    sq_t   nxt;
    root_t st_n;

    if (i < StatSteps) begin : g_stat
      assign st_n = root_step(sq_q[i].stat, 64'(1) << (StatTopBit - 2 * i));
    end else begin : g_hold
      assign st_n = sq_q[i].stat;
    end

    always_comb begin
      nxt      = sq_q[i];
      nxt.len  = root_step(sq_q[i].len, 64'(1) << (LenTopBit - 2 * i));
      nxt.stat = st_n;
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        sq_v_q[i+1] <= 1'b0;
      end else begin
        sq_v_q[i+1] <= sq_v_q[i];
      end
    end

    always_ff @(posedge clk_i) begin
      sq_q[i+1] <= nxt;
    end
  end

  // restoring divide: one quotient bit per stage, both axes in parallel
  for (genvar k = 0; k < DivSteps; k++) begin : g_div
    localparam int Pos = DivSteps - 1 - k;
    dv_t         nxt;
    logic [47:0] dvs;

    always_comb begin
      dvs = {17'b0, dv_q[k].len} << Pos;
      nxt = dv_q[k];
      if (dv_q[k].rx >= dvs) begin
        nxt.rx      = dv_q[k].rx - dvs;
        nxt.qx[Pos] = 1'b1;
      end
      if (dv_q[k].ry >= dvs) begin
        nxt.ry      = dv_q[k].ry - dvs;
        nxt.qy[Pos] = 1'b1;
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        dv_v_q[k+1] <= 1'b0;
      end else begin
        dv_v_q[k+1] <= dv_v_q[k];
      end
    end

    always_ff @(posedge clk_i) begin
      dv_q[k+1] <= nxt;
    end
  end

  assign done_o     = done_q;
  assign force_x_o  = force_x_q;
  assign force_y_o  = force_y_q;
  assign sticking_o = sticking_q;

`ifndef NO_ASSERTIONS
  a_norm_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (v6_q && !ctx6_q.zero) |-> (ax6_q[29] || ay6_q[29]))
    else $error("normalized tangent out of range");

  a_unit_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (dv_v_q[DivSteps] && !dv_q[DivSteps].ctx.zero) |->
      (dv_q[DivSteps].qx <= 17'h10000 && dv_q[DivSteps].qy <= 17'h10000))
    else $error("unit tangent component above one");

  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(start_i && !busy_o, Latency))
    else $error("result word without matching contact");
`endif

endmodule
`default_nettype wire

/* bench/contact_friction_force_test.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// contact_friction_force_test: self-checking bench for the friction pipeline
// Drives directed and random contacts with random gaps. A scoreboard class
// predicts each force in 64/128 bit integer math and checks every result
// word in order.
// ----------------------------------------------------------------------------
module contact_friction_force_test
  import cff_pkg::*;
;

  typedef struct {
    logic signed [31:0] nx, ny, vx, vy;
    logic [30:0]        dep;
    logic [15:0]        da, db, sa, sb;
  } contact_t;

  typedef struct {
    logic signed [31:0] fx, fy;
    logic               stick;
  } friction_t;

  class friction_board;
    friction_t pending[$];
    int        mismatches;
    int        checked;

    function automatic longint sat(input logic signed [127:0] x);
      if (x > 128'sh7FFF_FFFF) return 64'sh7FFF_FFFF;
      if (x < -128'sh8000_0000) return -64'sh8000_0000;
      return longint'(x);
    endfunction

    function automatic logic [63:0] root(input logic [63:0] x);
      logic [63:0] r, b;
      r = 0;
      b = 64'd1 << 62;
      while (b > x) b >>= 2;
      while (b != 0) begin
        if (x >= r + b) begin
          x = x - (r + b);
          r = (r >> 1) + b;
        end else begin
          r = r >> 1;
        end
        b >>= 2;
      end
      return r;
    endfunction

    function automatic void note(input contact_t c);
      logic signed [127:0] d, tx, ty, jt, k, fx, fy, ux, uy, thr;
      logic [63:0] ax, ay, m, len, jm;
      logic [15:0] dyn;
      logic [63:0] stat;
      friction_t r;
      ux = 0;
      uy = 0;
      d = sat((128'(c.vx) * c.nx >>> 16) + (128'(c.vy) * c.ny >>> 16));
      tx = c.vx - (d * c.nx >>> 16);
      ty = c.vy - (d * c.ny >>> 16);
      ax = tx < 0 ? 64'(-tx) : 64'(tx);
      ay = ty < 0 ? 64'(-ty) : 64'(ty);
      m = ax > ay ? ax : ay;
      if (m != 0) begin
        while (m >= (64'd1 << 30)) begin
          ax >>= 1; ay >>= 1; m >>= 1;
        end
        while (m < (64'd1 << 29)) begin
          ax <<= 1; ay <<= 1; m <<= 1;
        end
        len = root(ax * ax + ay * ay);
        ux = (ax << 16) / len;
        uy = (ay << 16) / len;
        if (tx < 0) ux = -ux;
        if (ty < 0) uy = -uy;
      end
      jt = -((128'(c.vx) * ux + 128'(c.vy) * uy) >>> 16);
      dyn = c.da < c.db ? c.da : c.db;
      stat = root(64'(c.sa) * c.sb);
      thr = 128'(c.dep) * stat;
      jm = jt < 0 ? 64'(-jt) : 64'(jt);
      r.stick = (128'(jm) << 12) < thr;
      if (r.stick) begin
        fx = ux * jt >>> 16;
        fy = uy * jt >>> 16;
      end else begin
        k = -(128'(c.dep) * dyn);
        fx = ux * k >>> 28;
        fy = uy * k >>> 28;
      end
      r.fx = 32'(sat(fx));
      r.fy = 32'(sat(fy));
      pending = {pending, r};
    endfunction

    function automatic void check(input friction_t got);
      friction_t e;
      checked++;
      if (pending.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result word %0d %0d %0b",
                                       got.fx, got.fy, got.stick);
        return;
      end
      e = pending.pop_front();
      if (e.fx !== got.fx || e.fy !== got.fy || e.stick !== got.stick) begin
        mismatches++;
        if (mismatches <= 10)
          $display("mismatch: expected %0d %0d %0b, got %0d %0d %0b",
                   e.fx, e.fy, e.stick, got.fx, got.fy, got.stick);
      end
    endfunction
  endclass

  logic clk, rst_n, start, busy, done, sticking;
  logic signed [31:0] nx, ny, vx, vy, force_x, force_y;
  logic [30:0] depth;
  logic [15:0] da, db, sa, sb;
  friction_board board;
  int sent, sticks;

  contact_friction_force dut (
    .clk_i(clk), .rst_ni(rst_n), .start_i(start), .busy_o(busy),
    .normal_x_i(nx), .normal_y_i(ny), .velocity_x_i(vx), .velocity_y_i(vy),
    .depth_i(depth), .dyn_coef_a_i(da), .dyn_coef_b_i(db),
    .stat_coef_a_i(sa), .stat_coef_b_i(sb), .done_o(done),
    .force_x_o(force_x), .force_y_o(force_y), .sticking_o(sticking)
  );

  initial clk = 0;
  always #10 clk = ~clk;

  always @(posedge clk) begin
    friction_t got;
    if (rst_n && done) begin
      got.fx = force_x;
      got.fy = force_y;
      got.stick = sticking;
      if (sticking) sticks++;
      board.check(got);
    end
  end

  task automatic send(input contact_t c);
    int gap;
    gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 13);
    if (gap > 0) begin
      start <= 0;
      repeat (gap) @(negedge clk);
    end
    start <= 1;
    nx <= c.nx; ny <= c.ny; vx <= c.vx; vy <= c.vy;
    depth <= c.dep; da <= c.da; db <= c.db; sa <= c.sa; sb <= c.sb;
    @(posedge clk);
    while (busy) @(posedge clk);
    board.note(c);
    sent++;
    @(negedge clk);
  endtask

  function automatic logic signed [31:0] unit_q(input real a);
    return $rtoi(a * 65536.0);
  endfunction

  function automatic contact_t rand_contact();
    contact_t c;
    real a;
    int kind;
    kind = $urandom_range(0, 9);
    a = $urandom_range(0, 62831) / 10000.0;
    c.nx = unit_q($cos(a));
    c.ny = unit_q($sin(a));
    c.vx = $signed($urandom) >>> $urandom_range(0, 31);
    c.vy = $signed($urandom) >>> $urandom_range(0, 31);
    c.dep = 31'($urandom) >> $urandom_range(0, 30);
    c.da = 16'($urandom);
    c.db = 16'($urandom);
    c.sa = 16'($urandom);
    c.sb = 16'($urandom);
    if (kind == 0) begin
      c.nx = $urandom;
      c.ny = $urandom;
    end else if (kind == 1) begin
      c.vx = c.nx * $signed(16'($urandom)) >>> 4;
      c.vy = c.ny * $signed(16'($urandom)) >>> 4;
    end else if (kind == 2) begin
      c.vx = $urandom;
      c.vy = $urandom;
      c.dep = 31'($urandom);
    end
    return c;
  endfunction

  initial begin
    contact_t c;
    logic signed [31:0] ext[4];
    ext = '{32'sh7FFF_FFFF, -32'sh8000_0000, 0, -1};
    board = new();
    sent = 0;
    sticks = 0;
    rst_n = 0;
    start = 0;
    {nx, ny, vx, vy} = '0;
    depth = 0;
    {da, db, sa, sb} = '0;
    repeat (4) @(negedge clk);
    rst_n = 1;
    @(negedge clk);
    // extremes of every field
    foreach (ext[i]) begin
      c.nx = ext[i]; c.ny = ext[3 - i]; c.vx = ext[(i + 1) % 4]; c.vy = ext[(i + 2) % 4];
      c.dep = i[0] ? 31'h7FFF_FFFF : 0;
      c.da = i[1] ? 16'hFFFF : 0; c.db = i[0] ? 16'hFFFF : 0;
      c.sa = i[0] ? 16'hFFFF : 0; c.sb = i[1] ? 16'hFFFF : 0;
      send(c);
    end
    // zero tangent: velocity along the normal, with and without threshold
    c.nx = 32'sh1_0000; c.ny = 0; c.vx = 32'sh5_0000; c.vy = 0;
    c.dep = 31'h1_0000; c.da = 16'h1000; c.db = 16'h0800; c.sa = 16'h1000; c.sb = 16'h1000;
    send(c);
    c.sa = 0;
    send(c);
    c.vx = 0;
    send(c);
    // sticking and sliding with a unit normal
    c.nx = 0; c.ny = 32'sh1_0000; c.vx = 32'sh0_4000; c.vy = 32'sh2_0000;
    c.sa = 16'hF000; c.sb = 16'hF000; c.dep = 31'h10_0000;
    send(c);
    c.vx = -32'sh40_0000; c.dep = 31'h100;
    send(c);
    // non-unit normal and saturated projection
    c.nx = 32'sh7FFF_FFFF; c.ny = 32'sh7FFF_FFFF; c.vx = 32'sh7FFF_FFFF;
    c.vy = -32'sh7FFF_0000; c.dep = 31'h7FFF_FFFF;
    send(c);
    c.nx = 32'sh0_0100; c.ny = -32'sh3_0000;
    send(c);
    repeat (650) send(rand_contact());
    start <= 0;
    while (board.pending.size() != 0) @(posedge clk);
    repeat (Latency + 10) @(posedge clk);
    $display("sent %0d contacts, checked %0d results, %0d sticking",
             sent, board.checked, sticks);
    $display("%0d mismatches", board.mismatches);
    if (board.mismatches == 0) begin
      $display("contact_friction_force_test: clean");
    end else begin
      $display("contact_friction_force_test: errors");
    end
    $finish;
  end

  initial begin
    #5ms;
    $display("contact_friction_force_test: errors");
    $finish;
  end

endmodule
